>>> hdl/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg: shared types and codes for the GPIO task/event channel block
// Transaction payloads, operation codes, channel modes, polarity and pin actions.
// ----------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

	// Default and maximum number of channels
	localparam int unsigned CHANNELS_DEF = 8;
	localparam int unsigned CHANNELS_MAX = 8;

	// Operation codes carried in the mode field
	localparam logic [3:0] MODE_OUT        = 4'd0;
	localparam logic [3:0] MODE_SET        = 4'd1;
	localparam logic [3:0] MODE_CLR        = 4'd2;
	localparam logic [3:0] MODE_PIN_CHANGE = 4'd3;
	localparam logic [3:0] MODE_PORT_DET   = 4'd4;
	localparam logic [3:0] MODE_WR_IN      = 4'd5;
	localparam logic [3:0] MODE_WR_PORT    = 4'd6;
	localparam logic [3:0] MODE_EN_SET     = 4'd7;
	localparam logic [3:0] MODE_EN_CLR     = 4'd8;
	localparam logic [3:0] MODE_CONFIG     = 4'd9;

	// Channel modes
	localparam logic [1:0] CM_DISABLED = 2'd0;
	localparam logic [1:0] CM_EVENT    = 2'd1;
	localparam logic [1:0] CM_TASK     = 2'd3;

	// Polarity codes
	localparam logic [1:0] POL_NONE   = 2'd0;
	localparam logic [1:0] POL_LOHI   = 2'd1;
	localparam logic [1:0] POL_HILO   = 2'd2;
	localparam logic [1:0] POL_TOGGLE = 2'd3;

	// Pin actions
	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_CONN_IN  = 2'd1;
	localparam logic [1:0] ACT_CONN_OUT = 2'd2;
	localparam logic [1:0] ACT_DRIVE    = 2'd3;

	// Event index of the port event
	localparam logic [3:0] EVT_PORT = 4'd8;

	// Input transaction
	typedef struct packed {
		logic [3:0] mode;
		logic [2:0] channel;
		logic       port;
		logic [4:0] pin;
		logic       value;
		logic [8:0] mask;
		logic [1:0] cfg_mode;
		logic [1:0] cfg_polarity;
		logic       cfg_outinit;
	} item_t;

	// Result transaction
	typedef struct packed {
		logic       release_valid;
		logic       release_port;
		logic [4:0] release_pin;
		logic [1:0] pin_action;
		logic       action_port;
		logic [4:0] action_pin;
		logic       action_level;
		logic       event_valid;
		logic [3:0] event_index;
		logic       irq_line;
		logic [8:0] event_flags;
		logic [8:0] enable_bits;
	} result_t;

	// Outcome of the pin-change channel search
	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} match_t;

endpackage : gte_pkg

`default_nettype wire

>>> hdl/gpio_task_event_channels.sv
// An accepted transaction sits in the input register until its result is registered.
// Throughput: one transaction per cycle; the input stage and the result register
// both advance whenever the result register is empty or its result is taken.
// The whole evaluation, including the per-channel search, sits in the one
// stage between the input register and the result register.
// Reset: arst_n clears all channel state, event latches, enables and valid flags.
// ----------------------------------------------------------------------------
// gpio_task_event_channels: GPIO task/event channel block, top level
// Input register, single-pass evaluation core and result register with
// valid/stall handshakes on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_task_event_channels
	import gte_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	item_t   item_s1;
	logic    vld_s1;
	result_t result_s2;
	logic    vld_s2;
	result_t res_d;
	logic    advance;
	logic    fire;

	// Pipeline moves when the result register is free or being emptied
	assign advance    = !vld_s2 || !result_stall;
	assign fire       = vld_s1 && advance;
	assign item_stall = vld_s1 && !advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	gte_core #(
		.CHANNELS(CHANNELS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.result(res_d)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= res_d;
		end
	end

	assign result_valid = vld_s2;
	assign result       = result_s2;

endmodule : gpio_task_event_channels

`default_nettype wire

>>> hdl/gte_match.sv
// ----------------------------------------------------------------------------
// gte_match: pin-change channel search
// Finds the lowest event-mode channel bound to the given port and pin.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_match
	import gte_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  wire logic [1:0] chan_mode [CHANNELS],
	input  wire logic       chan_port [CHANNELS],
	input  wire logic [4:0] chan_pin  [CHANNELS],
	input  wire logic       port,
	input  wire logic [4:0] pin,
	output match_t          match
);

	// Parallel compare, priority to the lowest channel
	always_comb begin
		match = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (chan_mode[i] == CM_EVENT && chan_port[i] == port && chan_pin[i] == pin) begin
				match.hit = 1'b1;
				match.idx = 3'(i);
			end
		end
	end

endmodule : gte_match

`default_nettype wire

>>> hdl/gte_core.sv
// ----------------------------------------------------------------------------
// gte_core: channel state and single-pass transaction evaluation
// Holds channel configuration, levels, event latches and interrupt enables,
// and computes the result of the transaction in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_core
	import gte_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire item_t   item,
	output result_t      result
);

	localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [7:0]  CH_MASK = 8'((16'd1 << CHANNELS) - 16'd1);
	localparam logic [8:0]  IMPL_MASK = {1'b1, CH_MASK};

	// Channel state
	logic [1:0] mode_q [CHANNELS];
	logic       port_q [CHANNELS];
	logic [4:0] pin_q  [CHANNELS];
	logic [1:0] pol_q  [CHANNELS];
	logic       lvl_q  [CHANNELS];

	// Event latches and enables
	logic [7:0] inev_q;
	logic       port_ev_q;
	logic [8:0] en_q;

	// Next-state controls
	logic            ch_ok;
	logic [CH_W-1:0] ch_idx;
	logic [CH_W-1:0] m_idx;
	logic            lvl_we;
	logic [CH_W-1:0] lvl_idx;
	logic            lvl_d;
	logic            cfg_we;
	logic [7:0]      inev_d;
	logic            port_ev_d;
	logic [8:0]      en_d;
	logic [8:0]      flags;
	logic            ev;
	match_t          m;

	gte_match #(
		.CHANNELS(CHANNELS)
	) u_match (
		.chan_mode(mode_q),
		.chan_port(port_q),
		.chan_pin (pin_q),
		.port     (item.port),
		.pin      (item.pin),
		.match    (m)
	);

	assign ch_ok  = {1'b0, item.channel} < 4'(CHANNELS);
	assign ch_idx = CH_W'(item.channel);
	assign m_idx  = CH_W'(m.idx);

	// Decode and evaluate the transaction
	always_comb begin
		result    = '0;
		lvl_we    = 1'b0;
		lvl_idx   = ch_idx;
		lvl_d     = 1'b0;
		cfg_we    = 1'b0;
		inev_d    = inev_q;
		port_ev_d = port_ev_q;
		en_d      = en_q;
		ev        = 1'b0;
		unique case (item.mode) inside
			MODE_OUT: begin
				if (ch_ok && mode_q[ch_idx] == CM_TASK && pol_q[ch_idx] != POL_NONE) begin
					lvl_we = 1'b1;
					case (pol_q[ch_idx])
						POL_LOHI: lvl_d = 1'b1;
						POL_HILO: lvl_d = 1'b0;
						default:  lvl_d = ~lvl_q[ch_idx];
					endcase
					result.pin_action   = ACT_DRIVE;
					result.action_port  = port_q[ch_idx];
					result.action_pin   = pin_q[ch_idx];
					result.action_level = lvl_d;
				end
			end
			MODE_SET, MODE_CLR: begin
				if (ch_ok && mode_q[ch_idx] == CM_TASK) begin
					lvl_we = 1'b1;
					lvl_d  = (item.mode == MODE_SET);
					result.pin_action   = ACT_DRIVE;
					result.action_port  = port_q[ch_idx];
					result.action_pin   = pin_q[ch_idx];
					result.action_level = lvl_d;
				end
			end
			MODE_PIN_CHANGE: begin
				if (m.hit) begin
					lvl_we  = 1'b1;
					lvl_idx = m_idx;
					lvl_d   = item.value;
					case (pol_q[m_idx])
						POL_LOHI:   ev = !lvl_q[m_idx] && item.value;
						POL_HILO:   ev = lvl_q[m_idx] && !item.value;
						POL_TOGGLE: ev = lvl_q[m_idx] != item.value;
						default:    ev = 1'b0;
					endcase
					if (ev) begin
						inev_d[m.idx]      = 1'b1;
						result.event_valid = 1'b1;
						result.event_index = {1'b0, m.idx};
					end
				end
			end
			MODE_PORT_DET: begin
				port_ev_d          = 1'b1;
				result.event_valid = 1'b1;
				result.event_index = EVT_PORT;
			end
			MODE_WR_IN: begin
				if (ch_ok) begin
					inev_d[item.channel] = item.value;
				end
			end
			MODE_WR_PORT: begin
				port_ev_d = item.value;
			end
			MODE_EN_SET: begin
				en_d = (en_q | item.mask) & IMPL_MASK;
			end
			MODE_EN_CLR: begin
				en_d = (en_q & ~item.mask) & IMPL_MASK;
			end
			MODE_CONFIG: begin
				if (ch_ok) begin
					cfg_we = 1'b1;
					// Old pin released when the binding moves or the channel is disabled
					if (item.port != port_q[ch_idx] || item.pin != pin_q[ch_idx] ||
					    (item.cfg_mode == CM_DISABLED && mode_q[ch_idx] != CM_DISABLED)) begin
						result.release_valid = 1'b1;
						result.release_port  = port_q[ch_idx];
						result.release_pin   = pin_q[ch_idx];
					end
					if (item.cfg_mode == CM_EVENT) begin
						lvl_we = 1'b1;
						lvl_d  = item.value;
						result.pin_action  = ACT_CONN_IN;
						result.action_port = item.port;
						result.action_pin  = item.pin;
					end else if (item.cfg_mode == CM_TASK) begin
						lvl_we = 1'b1;
						lvl_d  = item.cfg_outinit;
						result.pin_action   = ACT_CONN_OUT;
						result.action_port  = item.port;
						result.action_pin   = item.pin;
						result.action_level = item.cfg_outinit;
					end
				end
			end
			default: begin
			end
		endcase
		flags               = {port_ev_d, inev_d};
		result.event_flags  = flags;
		result.enable_bits  = en_d;
		result.irq_line     = |(flags & en_d);
	end

	// State update on each transaction that leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				mode_q[i] <= CM_DISABLED;
				port_q[i] <= 1'b0;
				pin_q[i]  <= '0;
				pol_q[i]  <= POL_NONE;
				lvl_q[i]  <= 1'b0;
			end
			inev_q    <= '0;
			port_ev_q <= 1'b0;
			en_q      <= '0;
		end else if (fire) begin
			if (cfg_we) begin
				mode_q[ch_idx] <= item.cfg_mode;
				port_q[ch_idx] <= item.port;
				pin_q[ch_idx]  <= item.pin;
				pol_q[ch_idx]  <= item.cfg_polarity;
			end
			if (lvl_we) begin
				lvl_q[lvl_idx] <= lvl_d;
			end
			inev_q    <= inev_d;
			port_ev_q <= port_ev_d;
			en_q      <= en_d;
		end
	end

	// Port detect always latches the port event
	a_port_det: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_PORT_DET |=> port_ev_q)
		else $error("port event not latched after port detect");

	// Enables of absent channels never stick
	a_en_impl: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (en_q & ~IMPL_MASK) == '0)
		else $error("enable bit stored for an absent channel");

	// Enable clear removes every masked bit
	a_en_clr: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_EN_CLR |=> (en_q & $past(item.mask)) == '0)
		else $error("enable clear left a masked bit set");

	// A signaled channel event is latched
	a_ev_latch: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.event_valid && result.event_index != EVT_PORT |=>
		inev_q[$past(result.event_index[2:0])])
		else $error("signaled channel event not latched");

endmodule : gte_core

`default_nettype wire

>>> test/gpio_task_event_channels_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpio_task_event_channels_test: self-checking bench for the GPIO task/event block
// A queued driver and a clocked monitor with random idling on both sides. The
// expected response of every accepted transaction is predicted from a private
// copy of the channel, latch and enable state.
// ----------------------------------------------------------------------------

module gpio_task_event_channels_test;
	import gte_pkg::*;

	localparam int unsigned CHANNELS      = CHANNELS_DEF;
	localparam int unsigned RANDOM_ITEMS  = 1250;
	localparam logic [1:0]  CM_INERT      = 2'd2;   // reserved mode, stored but does nothing
	localparam logic [3:0]  MODE_FIRST_UNUSED = 4'd10;
	localparam logic [3:0]  MODE_LAST_CODE    = 4'd15;
	localparam logic [8:0]  EN_IMPL = {1'b1, 8'((1 << CHANNELS) - 1)};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	gpio_task_event_channels DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Predictor state
	logic [1:0] ch_mode  [CHANNELS] = '{default: '0};
	logic       ch_port  [CHANNELS] = '{default: '0};
	logic [4:0] ch_pin   [CHANNELS] = '{default: '0};
	logic [1:0] ch_pol   [CHANNELS] = '{default: '0};
	logic       ch_level [CHANNELS] = '{default: '0};
	logic [7:0] latched_in   = '0;
	logic       latched_port = 1'b0;
	logic [8:0] irq_mask     = '0;

	// Shadow of channel bindings, used only to aim the generated stimulus
	logic [1:0] plan_mode [CHANNELS] = '{default: '0};
	logic       plan_port [CHANNELS] = '{default: '0};
	logic [4:0] plan_pin  [CHANNELS] = '{default: '0};

	item_t   pending_items[$];
	result_t expected_responses[$];
	int      total_items    = 0;
	int      items_accepted = 0;
	int      results_seen   = 0;
	int      errors         = 0;
	logic    item_taken     = 1'b0;

	// Next state and response of the block for one transaction
	function automatic result_t gpio_response(item_t it);
		result_t    r;
		int unsigned c;
		int         hit;
		logic       fire;
		logic       driven;
		logic [8:0] flags;
		r = '0;
		c = it.channel;
		hit = -1;
		fire = 1'b0;
		driven = 1'b0;
		case (it.mode)
			MODE_OUT: begin
				if (c < CHANNELS && ch_mode[c] == CM_TASK && ch_pol[c] != POL_NONE) begin
					case (ch_pol[c])
						POL_LOHI: ch_level[c] = 1'b1;
						POL_HILO: ch_level[c] = 1'b0;
						default:  ch_level[c] = ~ch_level[c];
					endcase
					driven = 1'b1;
				end
			end
			MODE_SET, MODE_CLR: begin
				if (c < CHANNELS && ch_mode[c] == CM_TASK) begin
					ch_level[c] = (it.mode == MODE_SET);
					driven = 1'b1;
				end
			end
			MODE_PIN_CHANGE: begin
				// lowest event-mode channel bound to this pin wins
				for (int i = 0; i < CHANNELS; i++)
					if (hit < 0 && ch_mode[i] == CM_EVENT && ch_port[i] == it.port &&
					    ch_pin[i] == it.pin)
						hit = i;
				if (hit >= 0) begin
					case (ch_pol[hit])
						POL_LOHI:   fire = !ch_level[hit] && it.value;
						POL_HILO:   fire = ch_level[hit] && !it.value;
						POL_TOGGLE: fire = ch_level[hit] != it.value;
						default:    fire = 1'b0;
					endcase
					ch_level[hit] = it.value;
					if (fire) begin
						latched_in[hit] = 1'b1;
						r.event_valid = 1'b1;
						r.event_index = 4'(hit);
					end
				end
			end
			MODE_PORT_DET: begin
				latched_port = 1'b1;
				r.event_valid = 1'b1;
				r.event_index = EVT_PORT;
			end
			MODE_WR_IN:   if (c < CHANNELS) latched_in[c] = it.value;
			MODE_WR_PORT: latched_port = it.value;
			MODE_EN_SET:  irq_mask = (irq_mask | it.mask) & EN_IMPL;
			MODE_EN_CLR:  irq_mask = irq_mask & ~it.mask & EN_IMPL;
			MODE_CONFIG: begin
				if (c < CHANNELS) begin
					// old pin is let go when the binding moves or the channel is shut off
					if (it.port != ch_port[c] || it.pin != ch_pin[c] ||
					    (it.cfg_mode == CM_DISABLED && ch_mode[c] != CM_DISABLED)) begin
						r.release_valid = 1'b1;
						r.release_port  = ch_port[c];
						r.release_pin   = ch_pin[c];
					end
					ch_mode[c] = it.cfg_mode;
					ch_port[c] = it.port;
					ch_pin[c]  = it.pin;
					ch_pol[c]  = it.cfg_polarity;
					if (it.cfg_mode == CM_EVENT) begin
						ch_level[c] = it.value;
						r.pin_action = ACT_CONN_IN;
						r.action_port = it.port;
						r.action_pin = it.pin;
					end else if (it.cfg_mode == CM_TASK) begin
						ch_level[c] = it.cfg_outinit;
						r.pin_action = ACT_CONN_OUT;
						r.action_port = it.port;
						r.action_pin = it.pin;
						r.action_level = it.cfg_outinit;
					end
				end
			end
			default: ;
		endcase
		if (driven) begin
			r.pin_action   = ACT_DRIVE;
			r.action_port  = ch_port[c];
			r.action_pin   = ch_pin[c];
			r.action_level = ch_level[c];
		end
		flags = {latched_port, latched_in};
		r.irq_line    = |(flags & irq_mask);
		r.event_flags = flags;
		r.enable_bits = irq_mask;
		return r;
	endfunction

	function automatic item_t make_item(logic [3:0] mode, int ch, logic port, int pin,
		logic value, logic [8:0] mask, logic [1:0] cm, logic [1:0] pol, logic init);
		item_t it;
		it = '{mode: mode, channel: 3'(ch), port: port, pin: 5'(pin), value: value,
			mask: mask, cfg_mode: cm, cfg_polarity: pol, cfg_outinit: init};
		return it;
	endfunction

	task automatic queue_item(item_t it);
		if (it.mode == MODE_CONFIG) begin
			plan_mode[it.channel] = it.cfg_mode;
			plan_port[it.channel] = it.port;
			plan_pin[it.channel]  = it.pin;
		end
		pending_items.push_back(it);
		total_items++;
	endtask

	// Random channel in the wanted mode, any channel if none is
	function automatic int pick_channel(logic [1:0] want);
		int hits[$];
		for (int i = 0; i < CHANNELS; i++)
			if (plan_mode[i] == want)
				hits.push_back(i);
		if (hits.size() == 0)
			return $urandom_range(CHANNELS - 1);
		return hits[$urandom_range(hits.size() - 1)];
	endfunction

	// Mostly short gaps, now and then a long one; none during a calm stretch
	function automatic int idle_length(logic calm);
		int roll;
		roll = $urandom_range(99);
		if (calm || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	task automatic check_field(string name, logic [8:0] exp_val, logic [8:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// Driver: new transaction at the falling edge once the last one was taken
	int   send_gap = 0;
	int   send_phase = 0;
	logic send_calm = 1'b0;
	always @(negedge clk) begin
		if (send_phase == 0) begin
			send_calm <= ($urandom_range(3) == 0);
			send_phase <= $urandom_range(150, 40);
		end else begin
			send_phase <= send_phase - 1;
		end
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !item_taken) begin
			// held until accepted
		end else if (send_gap > 0) begin
			item_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_items.size() > 0) begin
			item <= pending_items.pop_front();
			item_valid <= 1'b1;
			send_gap <= idle_length(send_calm);
		end else begin
			item_valid <= 1'b0;
		end
	end

	// Receiver stall, with one long hold-off to back the block up
	int   hold_left = 0;
	int   recv_phase = 0;
	logic recv_calm = 1'b0;
	logic long_hold_done = 1'b0;
	always @(negedge clk) begin
		if (recv_phase == 0) begin
			recv_calm <= ($urandom_range(3) == 0);
			recv_phase <= $urandom_range(150, 40);
		end else begin
			recv_phase <= recv_phase - 1;
		end
		if (!long_hold_done && results_seen >= 400) begin
			long_hold_done <= 1'b1;
			hold_left <= 300;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			hold_left <= idle_length(recv_calm);
			result_stall <= 1'b0;
		end
	end

	// Monitor: check accepted results, then predict for the accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_responses.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, result);
					errors++;
				end else begin
					result_t exp_r;
					exp_r = expected_responses.pop_front();
					check_field("release_valid", 9'(exp_r.release_valid),
						9'(result.release_valid));
					check_field("release_port",  9'(exp_r.release_port),
						9'(result.release_port));
					check_field("release_pin",   9'(exp_r.release_pin),
						9'(result.release_pin));
					check_field("pin_action",    9'(exp_r.pin_action),
						9'(result.pin_action));
					check_field("action_port",   9'(exp_r.action_port),
						9'(result.action_port));
					check_field("action_pin",    9'(exp_r.action_pin),
						9'(result.action_pin));
					check_field("action_level",  9'(exp_r.action_level),
						9'(result.action_level));
					check_field("event_valid",   9'(exp_r.event_valid),
						9'(result.event_valid));
					check_field("event_index",   9'(exp_r.event_index),
						9'(result.event_index));
					check_field("irq_line",      9'(exp_r.irq_line),
						9'(result.irq_line));
					check_field("event_flags",   exp_r.event_flags,   result.event_flags);
					check_field("enable_bits",   exp_r.enable_bits,   result.enable_bits);
				end
			end
			if (item_valid && !item_stall) begin
				expected_responses.push_back(gpio_response(item));
				items_accepted++;
			end
		end else begin
			item_taken <= 1'b0;
		end
	end

	// Stimulus and end of run
	initial begin
		item_t      it;
		logic [31:0] raw;
		int         roll;
		int         c;

		// directed: task, event, latch and enable corners
		queue_item(make_item(MODE_CONFIG, 0, 0, 0, 0, '0, CM_EVENT, POL_LOHI, 0));
		queue_item(make_item(MODE_CONFIG, 7, 1, 31, 0, '0, CM_TASK, POL_TOGGLE, 1));
		queue_item(make_item(MODE_OUT, 7, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_SET, 7, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_CLR, 7, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_OUT, 0, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_CONFIG, 6, 0, 9, 0, '0, CM_TASK, POL_NONE, 0));
		queue_item(make_item(MODE_OUT, 6, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_EN_SET, 0, 0, 0, 0, 9'h1FF, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_PIN_CHANGE, 0, 0, 0, 1, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_PIN_CHANGE, 0, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_PIN_CHANGE, 0, 1, 5, 1, '0, CM_DISABLED, POL_NONE, 0));
		// shared pin: only the event-mode channel may take the change
		queue_item(make_item(MODE_CONFIG, 1, 0, 3, 0, '0, CM_INERT, POL_TOGGLE, 1));
		queue_item(make_item(MODE_CONFIG, 2, 0, 3, 1, '0, CM_EVENT, POL_HILO, 0));
		queue_item(make_item(MODE_CONFIG, 3, 0, 3, 0, '0, CM_TASK, POL_TOGGLE, 0));
		queue_item(make_item(MODE_PIN_CHANGE, 0, 0, 3, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_PORT_DET, 0, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_EN_CLR, 0, 0, 0, 0, 9'h0FF, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_WR_IN, 5, 0, 0, 1, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_WR_IN, 0, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_WR_PORT, 0, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_WR_PORT, 0, 0, 0, 1, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_FIRST_UNUSED, 0, 0, 0, 0, '0, CM_DISABLED, POL_NONE, 0));
		queue_item(make_item(MODE_LAST_CODE, 7, 1, 31, 1, 9'h1FF, CM_TASK, POL_TOGGLE, 1));
		// shutting off an event channel on the same pin still releases it
		queue_item(make_item(MODE_CONFIG, 2, 0, 3, 0, '0, CM_DISABLED, POL_NONE, 0));

		// random: mostly configs and traffic aimed at bound pins
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			raw = $urandom;
			it = raw[$bits(item_t)-1:0];
			roll = $urandom_range(99);
			if (roll < 14) begin
				it.mode = MODE_CONFIG;
				if ($urandom_range(3) != 0)
					it.pin = 5'($urandom_range(3));
			end else if (roll < 44) begin
				it.mode = MODE_PIN_CHANGE;
				if (roll < 40) begin
					c = pick_channel(CM_EVENT);
					it.port = plan_port[c];
					it.pin  = plan_pin[c];
				end
			end else if (roll < 64) begin
				it.mode = 4'($urandom_range(MODE_CLR, MODE_OUT));
				if (roll < 60)
					it.channel = 3'(pick_channel(CM_TASK));
			end else if (roll < 68) begin
				it.mode = MODE_PORT_DET;
			end else if (roll < 75) begin
				it.mode = MODE_WR_IN;
			end else if (roll < 79) begin
				it.mode = MODE_WR_PORT;
			end else if (roll < 88) begin
				it.mode = MODE_EN_SET;
			end else if (roll < 97) begin
				it.mode = MODE_EN_CLR;
			end else begin
				it.mode = 4'($urandom_range(MODE_LAST_CODE, MODE_FIRST_UNUSED));
			end
			queue_item(it);
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (items_accepted != total_items || expected_responses.size() != 0);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hdl/gte_pkg.sv
hdl/gte_match.sv
hdl/gte_core.sv
hdl/gpio_task_event_channels.sv
test/gpio_task_event_channels_test.sv
